/* design/ssd_pkg.sv */
// Shared constants and types for the seven-segment serial display core.
`timescale 1ns / 1ps

package ssd_pkg;

   // Number of digit positions held by the display store
   localparam int DIGITS = 6;

   // Width of a digit index
   localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGITS - 1);

   localparam logic [7:0] DOT_BIT  = 8'h20;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CNT_MAX  = 8'hFF;

   // Action codes carried in req_tuser
   localparam logic [2:0] ACT_SET    = 3'd0;
   localparam logic [2:0] ACT_STRING = 3'd1;
   localparam logic [2:0] ACT_FILL   = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_SHOW   = 3'd4;

   typedef logic [7:0] seg_type;

endpackage

/* design/ssd_glyph_rom.sv */
// Character to segment mask lookup, case-insensitive.
`timescale 1ns / 1ps

module ssd_glyph_rom
   import ssd_pkg::*;
(
   input  logic [7:0] char_code,
   output seg_type    mask
);

   logic [7:0] upper;

   // Fold lower case onto upper case
   always_comb begin
      upper = char_code;
      if (char_code inside {[8'h61:8'h7A]}) begin
         upper = char_code - 8'h20;
      end
   end

   always_comb begin
      case (upper)
         "0":     mask = 8'hDD;
         "1":     mask = 8'h90;
         "2":     mask = 8'hC7;
         "3":     mask = 8'hD3;
         "4":     mask = 8'h9A;
         "5":     mask = 8'h5B;
         "6":     mask = 8'h5F;
         "7":     mask = 8'hD0;
         "8":     mask = 8'hDF;
         "9":     mask = 8'hDB;
         "A":     mask = 8'hDE;
         "B":     mask = 8'h1F;
         "C":     mask = 8'h07;
         "D":     mask = 8'h97;
         "E":     mask = 8'h4F;
         "F":     mask = 8'h4E;
         "H":     mask = 8'h1E;
         "R":     mask = 8'h06;
         "L":     mask = 8'h0D;
         "O":     mask = 8'h17;
         "Q":     mask = 8'h37;
         "P":     mask = 8'hCE;
         "T":     mask = 8'h0F;
         "U":     mask = 8'h15;
         "N":     mask = 8'h16;
         "-":     mask = 8'h02;
         "_":     mask = 8'h01;
         " ":     mask = 8'h00;
         default: mask = 8'h00;
      endcase
   end

endmodule

/* design/seven_segment_serial_display_core.sv */
// Top level of the seven-segment serial display core.
`timescale 1ns / 1ps

// The core keeps one segment byte per digit and takes one command word at a
// time on the req channel; req_tready is low while a command is in progress.
// Set, string and clear are captured, then executed in ST_EXEC. Fill walks
// the store one digit per cycle through a single compare. Show walks the store
// bit by bit, last digit first and MSB first, and emits one inverted serial
// bit per cycle, while the output slot is free, into a one-word output
// register, then a latch word with rsp_tlast set: DIGITS*8 + 1 result words
// in all. Back-pressure on rsp simply stretches the walk. The next command is
// taken while the final latch word still waits in the output register.
module seven_segment_serial_display_core
   import ssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] char_code, [15:8] position, [16] dot, [17] string_start, [23:18] zero
   input  logic [23:0] req_tdata,
   // [2:0] action
   input  logic [2:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] data_level, [7:1] zero
   output logic [7:0]  rsp_tdata,
   // [0] latch_pulse
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_SHOW
   } state_type;

   state_type        state_ff;

   // Captured command word
   logic [2:0]       action_ff;
   logic [7:0]       char_ff;
   logic [7:0]       pos_ff;
   logic             dot_ff;
   logic             start_ff;

   // Display store and string tracking
   seg_type          seg_ff [DIGITS];
   logic [7:0]       cnt_ff;
   logic [IDX_W-1:0] last_idx_ff;
   logic             last_valid_ff;

   // Walk counters: digit index shared by fill and show, bit and latch for show only
   logic [IDX_W-1:0] digit_ff;
   logic [2:0]       bit_ff;
   logic             latch_ff;

   // Output register
   logic             rsp_valid_ff;
   logic             rsp_data_ff;
   logic             rsp_user_ff;
   logic             rsp_last_ff;

   seg_type          glyph;
   logic             slot_free;
   logic [7:0]       cnt_base;
   logic             valid_base;
   logic [7:0]       cnt_next;
   logic [IDX_W-1:0] set_idx;
   logic [IDX_W-1:0] str_idx;
   seg_type          cur_seg;

   ssd_glyph_rom u_glyph (
      .char_code (char_ff),
      .mask      (glyph)
   );

   // Map a one-based position to an index; out of range lands on digit 1
   function automatic logic [IDX_W-1:0] pos_to_idx(input logic [7:0] pos);
      logic [7:0] dec;
      dec = pos - 8'd1;
      if (pos == 8'd0 || pos > 8'(DIGITS)) begin
         return '0;
      end
      return dec[IDX_W-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign cnt_base   = start_ff ? 8'd0 : cnt_ff;
   assign valid_base = start_ff ? 1'b0 : last_valid_ff;
   assign cnt_next   = (cnt_base < CNT_MAX) ? cnt_base + 8'd1 : cnt_base;
   assign set_idx    = pos_to_idx(pos_ff);
   assign str_idx    = pos_to_idx(cnt_next);
   assign cur_seg    = seg_ff[digit_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         for (int k = 0; k < DIGITS; k++) begin
            seg_ff[k] <= '0;
         end
         cnt_ff        <= '0;
         last_idx_ff   <= '0;
         last_valid_ff <= 1'b0;
         digit_ff      <= '0;
         bit_ff        <= '0;
         latch_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= 1'b0;
         rsp_user_ff   <= 1'b0;
         rsp_last_ff   <= 1'b0;
         action_ff     <= '0;
         char_ff       <= '0;
         pos_ff        <= '0;
         dot_ff        <= 1'b0;
         start_ff      <= 1'b0;
      end else begin
         // Drop the output word once taken; the show walk reloads it itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_SHOW) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  action_ff <= req_tuser;
                  char_ff   <= req_tdata[7:0];
                  pos_ff    <= req_tdata[15:8];
                  dot_ff    <= req_tdata[16];
                  start_ff  <= req_tdata[17];
                  state_ff  <= ST_EXEC;
               end
            end

            ST_EXEC: begin
               state_ff <= ST_IDLE;
               case (action_ff)
                  ACT_SET: begin
                     seg_ff[set_idx] <= glyph | (dot_ff ? DOT_BIT : 8'h00);
                  end
                  ACT_STRING: begin
                     if (char_ff == CHAR_DOT) begin
                        // Dot attaches to the previous string character
                        cnt_ff        <= cnt_base;
                        last_valid_ff <= valid_base;
                        if (valid_base) begin
                           seg_ff[last_idx_ff] <= seg_ff[last_idx_ff] | DOT_BIT;
                        end
                     end else begin
                        cnt_ff          <= cnt_next;
                        seg_ff[str_idx] <= glyph;
                        last_idx_ff     <= str_idx;
                        last_valid_ff   <= 1'b1;
                     end
                  end
                  ACT_FILL: begin
                     digit_ff <= '0;
                     state_ff <= ST_FILL;
                  end
                  ACT_CLEAR: begin
                     for (int k = 0; k < DIGITS; k++) begin
                        seg_ff[k] <= '0;
                     end
                  end
                  ACT_SHOW: begin
                     digit_ff <= IDX_LAST;
                     bit_ff   <= 3'd7;
                     latch_ff <= 1'b0;
                     state_ff <= ST_SHOW;
                  end
                  default: begin
                  end
               endcase
            end

            ST_FILL: begin
               // One digit per cycle: replace empty entries
               if (cur_seg == 8'h00) begin
                  seg_ff[digit_ff] <= glyph;
               end
               if (digit_ff == IDX_LAST) begin
                  state_ff <= ST_IDLE;
               end else begin
                  digit_ff <= digit_ff + IDX_W'(1);
               end
            end

            ST_SHOW: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (latch_ff) begin
                     rsp_data_ff <= 1'b0;
                     rsp_user_ff <= 1'b1;
                     rsp_last_ff <= 1'b1;
                     state_ff    <= ST_IDLE;
                  end else begin
                     rsp_data_ff <= ~cur_seg[bit_ff];
                     rsp_user_ff <= 1'b0;
                     rsp_last_ff <= 1'b0;
                     if (bit_ff == 3'd0) begin
                        bit_ff <= 3'd7;
                        if (digit_ff == '0) begin
                           latch_ff <= 1'b1;
                        end else begin
                           digit_ff <= digit_ff - IDX_W'(1);
                        end
                     end else begin
                        bit_ff <= bit_ff - 3'd1;
                     end
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the seven-segment serial display core.
`timescale 1ns / 1ps

module testbench;
   import ssd_pkg::*;

   // Run ends here no matter what; far above the slowest correct run
   localparam int CYCLE_LIMIT = 1000000;
   // Long receiver hold-off that backs the core up into its input
   localparam int HOLD_CYCLES = 400;
   // Quiet time after the last word; covers the longest command walk
   localparam int DRAIN_CYCLES = 100;
   // Random commands wanted after the directed part
   localparam int RANDOM_COMMANDS = 95;
   // String run long enough to wrap past the last digit
   localparam int SATURATION_CHARS = 8;

   // One expected word on the rsp channel
   typedef struct packed {
      logic level;
      logic latch;
      logic tail;
   } serial_word_type;

   // Shadow copy of the display store; turns each accepted command into the
   // serial words it should produce and matches the words that come out.
   class segment_shadow;
      seg_type              digit_store [DIGITS];
      logic [7:0]           run_count;
      int                   dot_slot;
      bit                   dot_ok;
      serial_word_type      pending_bits [$];
      int                   mismatches;

      function new();
         for (int d = 0; d < DIGITS; d++) digit_store[d] = '0;
         run_count   = '0;
         dot_slot    = 0;
         dot_ok      = 0;
         mismatches  = 0;
      endfunction

      // Case-insensitive glyph lookup; anything unknown is dark
      function seg_type glyph(logic [7:0] c);
         logic [7:0] u;
         u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
         case (u)
            "0": return 8'hDD;  "1": return 8'h90;  "2": return 8'hC7;
            "3": return 8'hD3;  "4": return 8'h9A;  "5": return 8'h5B;
            "6": return 8'h5F;  "7": return 8'hD0;  "8": return 8'hDF;
            "9": return 8'hDB;  "A": return 8'hDE;  "B": return 8'h1F;
            "C": return 8'h07;  "D": return 8'h97;  "E": return 8'h4F;
            "F": return 8'h4E;  "H": return 8'h1E;  "R": return 8'h06;
            "L": return 8'h0D;  "O": return 8'h17;  "Q": return 8'h37;
            "P": return 8'hCE;  "T": return 8'h0F;  "U": return 8'h15;
            "N": return 8'h16;  "-": return 8'h02;  "_": return 8'h01;
            " ": return 8'h00;
            default: return 8'h00;
         endcase
      endfunction

      // One-based position to store index; anything off the end goes to digit 1
      function int slot_of(logic [7:0] pos);
         if (pos == 0 || pos > DIGITS) return 0;
         return int'(pos) - 1;
      endfunction

      function void take_command(logic [2:0] action, logic [7:0] ch, logic [7:0] pos,
                                 logic dot, logic start);
         serial_word_type w;
         int              slot;
         case (action)
            ACT_SET:
               digit_store[slot_of(pos)] = glyph(ch) | (dot ? DOT_BIT : 8'h00);
            ACT_STRING: begin
               if (start) begin
                  run_count = '0;
                  dot_ok    = 0;
               end
               if (ch == CHAR_DOT) begin
                  if (dot_ok) digit_store[dot_slot] = digit_store[dot_slot] | DOT_BIT;
               end else begin
                  if (run_count != CNT_MAX) run_count = run_count + 8'd1;
                  slot              = slot_of(run_count);
                  digit_store[slot] = glyph(ch);
                  dot_slot          = slot;
                  dot_ok            = 1;
               end
            end
            ACT_FILL:
               for (int d = 0; d < DIGITS; d++)
                  if (digit_store[d] == 8'h00) digit_store[d] = glyph(ch);
            ACT_CLEAR:
               for (int d = 0; d < DIGITS; d++) digit_store[d] = '0;
            ACT_SHOW: begin
               // Last digit first, MSB first, pin level inverted
               for (int d = DIGITS - 1; d >= 0; d--)
                  for (int b = 7; b >= 0; b--) begin
                     w.level = ~digit_store[d][b];
                     w.latch = 1'b0;
                     w.tail  = 1'b0;
                     pending_bits.push_back(w);
                  end
               w.level = 1'b0;
               w.latch = 1'b1;
               w.tail  = 1'b1;
               pending_bits.push_back(w);
            end
            default: ;
         endcase
      endfunction

      function void match_bit(logic [7:0] tdata, logic tuser, logic tlast);
         serial_word_type w;
         if (pending_bits.size() == 0) begin
            $display("%0t: rsp word with nothing expected: tdata=%h tuser=%b tlast=%b",
                     $time, tdata, tuser, tlast);
            mismatches++;
            return;
         end
         w = pending_bits.pop_front();
         if (tdata !== {7'b0, w.level}) begin
            $display("%0t: rsp_tdata expected %h actual %h", $time, {7'b0, w.level}, tdata);
            mismatches++;
         end
         if (tuser !== w.latch) begin
            $display("%0t: rsp_tuser expected %b actual %b", $time, w.latch, tuser);
            mismatches++;
         end
         if (tlast !== w.tail) begin
            $display("%0t: rsp_tlast expected %b actual %b", $time, w.tail, tlast);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   segment_shadow shadow;
   int            cycle_count = 0;
   // Both sides run back to back while this is set
   bit            steady      = 0;
   bit            hold_armed  = 0;
   bit            hold_done   = 0;

   seven_segment_serial_display_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** seven_segment_serial_display_core: FAILED **");
         $finish;
      end
   end

   // Match every accepted rsp word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.match_bit(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Receiver: random stalls per word, one long hold-off mid-show
   initial begin
      int gap;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_armed && !hold_done && rsp_tvalid) begin
            // Hold off long enough for the output to back up into req_tready
            hold_done = 1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
               rsp_tready <= 1'b1;
            end else if (!rsp_tready) begin
               @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Offer one command word after a random gap; hold it until accepted
   task automatic send_word(logic [2:0] action, logic [7:0] ch, logic [7:0] pos,
                            logic dot, logic start);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {6'b0, start, dot, pos, ch};
      do @(posedge clock); while (!req_tready);
      shadow.take_command(action, ch, pos, dot, start);
   endtask

   // Mostly known glyphs, some lower case, some dots, some raw bytes
   function automatic logic [7:0] pick_char();
      string known;
      int    r;
      known = "0123456789ABCDEFHRLOQPTUN-_ ";
      r     = $urandom_range(0, 9);
      if (r <= 5) return known[$urandom_range(0, known.len() - 1)];
      if (r == 6) return 8'($urandom_range(8'h61, 8'h7A));
      if (r == 7) return CHAR_DOT;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly near the valid range, including both off-the-end neighbors
   function automatic logic [7:0] pick_pos();
      if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, DIGITS + 1));
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int         counted;
      int         len;
      int         kind;
      logic [7:0] ch;
      logic       start;

      shadow     = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_SET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: cleared store, set extremes, string edge cases, fill, unused codes
      send_word(ACT_SHOW,   8'h00, 8'd0,   1'b0, 1'b0);
      send_word(ACT_SET,    "8",   8'd1,   1'b1, 1'b0);
      send_word(ACT_SET,    "a",   8'd6,   1'b0, 1'b1);
      send_word(ACT_SET,    "7",   8'd0,   1'b0, 1'b0);
      send_word(ACT_SET,    "Z",   8'd7,   1'b1, 1'b0);
      send_word(ACT_SET,    CHAR_DOT, 8'd255, 1'b0, 1'b0);
      // Dot before any character of the string is dropped
      send_word(ACT_STRING, CHAR_DOT, 8'd0, 1'b1, 1'b1);
      send_word(ACT_STRING, "h",   8'd0,   1'b0, 1'b0);
      send_word(ACT_STRING, CHAR_DOT, 8'd0, 1'b0, 1'b0);
      send_word(ACT_STRING, "E",   8'd3,   1'b0, 1'b0);
      send_word(ACT_STRING, "L",   8'd255, 1'b1, 1'b0);
      send_word(ACT_STRING, "p",   8'd0,   1'b0, 1'b0);
      send_word(ACT_STRING, "-",   8'd0,   1'b0, 1'b0);
      send_word(ACT_STRING, "_",   8'd0,   1'b0, 1'b0);
      // Seventh character runs off the end and lands on digit 1
      send_word(ACT_STRING, " ",   8'd0,   1'b0, 1'b0);
      send_word(ACT_STRING, CHAR_DOT, 8'd0, 1'b0, 1'b0);
      send_word(ACT_SHOW,   8'hFF, 8'd255, 1'b1, 1'b1);
      send_word(ACT_CLEAR,  8'hFF, 8'd255, 1'b1, 1'b1);
      // String state survives clear
      send_word(ACT_STRING, "9",   8'd0,   1'b0, 1'b0);
      send_word(ACT_FILL,   "q",   8'd0,   1'b1, 1'b0);
      send_word(ACT_SHOW,   8'h00, 8'd0,   1'b0, 1'b0);
      send_word(3'd5,       "8",   8'd1,   1'b1, 1'b1);
      send_word(3'd7,       8'hFF, 8'd255, 1'b1, 1'b1);
      send_word(ACT_SET,    8'hFF, 8'd3,   1'b1, 1'b0);
      send_word(ACT_SHOW,   8'h00, 8'd0,   1'b0, 1'b0);

      // String with no restart that runs past the last digit
      for (int i = 0; i < SATURATION_CHARS; i++) begin
         ch = pick_char();
         if (ch == CHAR_DOT) ch = "8";
         send_word(ACT_STRING, ch, pick_pos(), 1'($urandom_range(0, 1)), 1'(i == 0));
      end
      send_word(ACT_STRING, CHAR_DOT, 8'd0, 1'b0, 1'b0);
      send_word(ACT_SHOW, 8'h00, 8'd0, 1'b0, 1'b0);

      // Random mix: mostly well-formed strings and shows, some noise
      hold_armed = 1;
      counted    = 0;
      while (counted < RANDOM_COMMANDS) begin
         steady = (counted >= 60 && counted < 90);
         kind   = $urandom_range(0, 99);
         if (kind < 30) begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++) begin
               ch    = (i > 0 && $urandom_range(0, 3) == 0) ? CHAR_DOT : pick_char();
               start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
               send_word(ACT_STRING, ch, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), start);
               counted++;
            end
         end else if (kind < 92) begin
            send_word((kind < 55) ? ACT_SET : (kind < 63) ? ACT_FILL :
                      (kind < 70) ? ACT_CLEAR : ACT_SHOW,
                      pick_char(), pick_pos(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            counted++;
         end else begin
            // Unused action codes; ignored by the core, not counted
            send_word(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
      end
      steady = 0;
      send_word(ACT_SHOW, 8'h00, 8'd0, 1'b0, 1'b0);

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain outstanding words, then give the core time to misbehave
      while (shadow.pending_bits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.mismatches == 0 && shadow.pending_bits.size() == 0) begin
         $display("** seven_segment_serial_display_core: PASSED **");
      end else begin
         if (shadow.pending_bits.size() != 0)
            $display("%0t: %0d rsp words expected but never seen", $time,
                     shadow.pending_bits.size());
         $display("** seven_segment_serial_display_core: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ssd_pkg.sv
design/ssd_glyph_rom.sv
design/seven_segment_serial_display_core.sv
test/testbench.sv
